[rtl/core/npic_pkg.sv]
// Package for the nested priority interrupt controller.
// Holds level and stack sizes, the saved context type and the result type.
// No dependencies.
`timescale 1ns / 1ps

package npic_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int LVL_W      = 3;
  localparam int TICK_W     = 8;
  localparam int SP_W       = $clog2(NUM_LEVELS + 1);
  localparam int IDX_W      = $clog2(NUM_LEVELS);

  localparam logic [TICK_W-1:0] SERVICE_TICKS_RST = TICK_W'(5);

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [TICK_W-1:0] ticks;
  } ctx_t;

  typedef struct packed {
    logic                  handler_done;
    logic [TICK_W-1:0]     ticks_left;
    logic [SP_W-1:0]       nesting_depth;
    logic [NUM_LEVELS-1:0] pending_mask;
    logic [LVL_W-1:0]      current_level;
  } result_t;

endpackage

[rtl/core/npic_stack.sv]
// Context stack of the nested priority interrupt controller.
// One write port, one asynchronous read port; depends on npic_pkg.
`timescale 1ns / 1ps

module npic_stack (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [npic_pkg::IDX_W-1:0] wr_idx_i,
  input  npic_pkg::ctx_t             wr_ctx_i,
  input  logic [npic_pkg::IDX_W-1:0] rd_idx_i,
  output npic_pkg::ctx_t             rd_ctx_o
);
  import npic_pkg::*;

  ctx_t mem_q [NUM_LEVELS];

  // entries are only read below the stack pointer, so they need no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_ctx_i;
    end
  end

  assign rd_ctx_o = mem_q[rd_idx_i];

endmodule

[rtl/core/npic_core.sv]
// Level state, pending bits and next-state logic of the interrupt controller.
// Processes one item per enabled cycle; depends on npic_pkg and npic_stack.
`timescale 1ns / 1ps

module npic_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        mode_i,
  input  logic [npic_pkg::LVL_W-1:0]  level_i,
  input  logic [npic_pkg::TICK_W-1:0] service_ticks_i,
  output npic_pkg::result_t           result_o
);
  import npic_pkg::*;

  logic [NUM_LEVELS-1:0] pend_q, pend_d;
  logic [LVL_W-1:0]      act_q, act_d;
  logic [TICK_W-1:0]     rem_q, rem_d;
  logic [SP_W-1:0]       sp_q, sp_d;

  logic [NUM_LEVELS-1:0] b_pend;
  logic [LVL_W-1:0]      b_act;
  logic [TICK_W-1:0]     b_rem;
  logic [SP_W-1:0]       b_sp;
  logic [TICK_W-1:0]     dec_rem;
  logic                  enter;
  logic [LVL_W-1:0]      enter_lvl;
  logic [LVL_W-1:0]      top_lvl;
  logic                  done;
  logic                  push;
  logic [IDX_W-1:0]      rd_idx;
  ctx_t                  rd_ctx;
  ctx_t                  wr_ctx;

  function automatic logic [LVL_W-1:0] highest(input logic [NUM_LEVELS-1:0] bits);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (bits[k]) begin
        lvl = LVL_W'(k + 1);
      end
    end
    return lvl;
  endfunction

  function automatic logic [NUM_LEVELS-1:0] level_bit(input logic [LVL_W-1:0] lvl);
    return {{(NUM_LEVELS-1){1'b0}}, 1'b1} << (lvl - LVL_W'(1));
  endfunction

  assign rd_idx  = IDX_W'(sp_q - SP_W'(1));
  assign dec_rem = rem_q - TICK_W'(1);

  // first half: set the request or count down and pop
  always_comb begin
    b_pend    = pend_q;
    b_act     = act_q;
    b_rem     = rem_q;
    b_sp      = sp_q;
    enter     = 1'b0;
    enter_lvl = level_i;
    done      = 1'b0;
    top_lvl   = '0;
    if (mode_i == MODE_REQUEST) begin
      if (level_i >= LVL_W'(1) && level_i <= LVL_W'(NUM_LEVELS)) begin
        b_pend = pend_q | level_bit(level_i);
        enter  = level_i > act_q;
      end
    end else if (act_q != '0) begin
      b_rem = dec_rem;
      if (dec_rem == '0) begin
        done = 1'b1;
        if (sp_q != '0) begin
          b_sp  = sp_q - SP_W'(1);
          b_act = rd_ctx.level;
          b_rem = rd_ctx.ticks;
        end else begin
          b_act = '0;
          b_rem = '0;
        end
        top_lvl   = highest(pend_q);
        enter     = top_lvl > b_act;
        enter_lvl = top_lvl;
      end
    end
  end

  // second half: preempt into the new level, saving the context if room
  always_comb begin
    pend_d = b_pend;
    act_d  = b_act;
    rem_d  = b_rem;
    sp_d   = b_sp;
    push   = 1'b0;
    wr_ctx = '{level: b_act, ticks: b_rem};
    if (enter) begin
      if (b_sp < SP_W'(NUM_LEVELS)) begin
        push = 1'b1;
        sp_d = b_sp + SP_W'(1);
      end
      act_d  = enter_lvl;
      rem_d  = service_ticks_i;
      pend_d = b_pend & ~level_bit(enter_lvl);
    end
  end

  npic_stack u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (en_i & push),
    .wr_idx_i (b_sp[IDX_W-1:0]),
    .wr_ctx_i (wr_ctx),
    .rd_idx_i (rd_idx),
    .rd_ctx_o (rd_ctx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      act_q  <= '0;
      rem_q  <= '0;
      sp_q   <= '0;
    end else if (en_i) begin
      pend_q <= pend_d;
      act_q  <= act_d;
      rem_q  <= rem_d;
      sp_q   <= sp_d;
    end
  end

  assign result_o.current_level = act_d;
  assign result_o.pending_mask  = pend_d;
  assign result_o.nesting_depth = sp_d;
  assign result_o.ticks_left    = (act_d == '0) ? '0 : rem_d;
  assign result_o.handler_done  = done;

endmodule

[rtl/core/nested_priority_interrupt_controller.sv]
// Nested priority interrupt controller: four levels above the main program.
// Each input transaction is a tick (tuser 0) or a request (tuser 1) and yields
// one result transaction. A transaction is registered on entry, then processed by
// the level logic and stack as it moves into a result register, where it is held;
// one transaction is taken every cycle while the result output does not stall.
// The service_ticks register (reset 5) is written through cfg_we_i.
// Depends on npic_pkg and npic_core.
`timescale 1ns / 1ps

module nested_priority_interrupt_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [npic_pkg::TICK_W-1:0] cfg_wdata_i,   // service_ticks
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [2:0] request_level
  input  logic                        s_axis_tuser,  // mode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [2:0] current_level, [6:3] pending_mask, [9:7] nesting_depth,
  // [17:10] ticks_left, [18] handler_done
  output logic [23:0]                 m_axis_tdata
);
  import npic_pkg::*;

  logic [TICK_W-1:0] service_ticks_q;
  logic              in_valid_q;
  logic              in_mode_q;
  logic [LVL_W-1:0]  in_level_q;
  logic              out_valid_q;
  result_t           out_res_q;
  result_t           res;
  logic              advance;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      service_ticks_q <= SERVICE_TICKS_RST;
    end else if (cfg_we_i) begin
      service_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // capture the transaction payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q  <= s_axis_tuser;
      in_level_q <= s_axis_tdata[LVL_W-1:0];
    end
  end

  npic_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .mode_i          (in_mode_q),
    .level_i         (in_level_q),
    .service_ticks_i (service_ticks_q),
    .result_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_res_q.handler_done, out_res_q.ticks_left,
                          out_res_q.nesting_depth, out_res_q.pending_mask,
                          out_res_q.current_level};

endmodule

[test/npic_checker.sv]
// Checker for the nested priority interrupt controller: watches both streams
// and the register port, predicts each result transaction and compares it.
// Depends on npic_pkg.
`timescale 1ns / 1ps

module npic_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [npic_pkg::TICK_W-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [2:0] request_level
  input  logic                        s_axis_tuser,   // mode
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [23:0]                 m_axis_tdata,   // result_t in [18:0], zeros above
  output int                          fail_count_o,
  output int                          waiting_o
);
  import npic_pkg::*;

  localparam int RES_W = $bits(result_t);

  // Shadow copy of the controller state
  logic [NUM_LEVELS-1:0] pending_q;
  logic [LVL_W-1:0]      level_q;
  logic [TICK_W-1:0]     ticks_q;
  logic [SP_W-1:0]       depth_q;
  ctx_t                  saved_q [NUM_LEVELS];
  logic [TICK_W-1:0]     service_ticks_q;

  result_t expected_status_q [$];

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    fail_count_o++;
  endtask

  function automatic void enter_handler(input logic [LVL_W-1:0] lvl);
    // drop the push on a full stack, switch level regardless
    if (depth_q < NUM_LEVELS) begin
      saved_q[depth_q[IDX_W-1:0]] = '{level: level_q, ticks: ticks_q};
      depth_q++;
    end
    level_q         = lvl;
    ticks_q         = service_ticks_q;
    pending_q[lvl - 1] = 1'b0;
  endfunction

  function automatic result_t predict_status(input logic mode,
                                             input logic [LVL_W-1:0] lvl);
    result_t          r;
    logic [LVL_W-1:0] top;
    logic             done;
    done = 1'b0;
    if (mode == MODE_REQUEST) begin
      if (lvl >= 1 && lvl <= NUM_LEVELS) begin
        pending_q[lvl - 1] = 1'b1;
        if (lvl > level_q)
          enter_handler(lvl);
      end
    end else if (level_q != 0) begin
      // a zero count wraps, so the handler runs the full 256 ticks
      ticks_q = ticks_q - 1'b1;
      if (ticks_q == 0) begin
        done = 1'b1;
        if (depth_q > 0) begin
          depth_q--;
          level_q = saved_q[depth_q[IDX_W-1:0]].level;
          ticks_q = saved_q[depth_q[IDX_W-1:0]].ticks;
        end else begin
          level_q = '0;
          ticks_q = '0;
        end
        top = '0;
        for (int k = 0; k < NUM_LEVELS; k++)
          if (pending_q[k])
            top = LVL_W'(k + 1);
        if (top > level_q)
          enter_handler(top);
      end
    end
    r.current_level = level_q;
    r.pending_mask  = pending_q;
    r.nesting_depth = depth_q;
    r.ticks_left    = (level_q == 0) ? '0 : ticks_q;
    r.handler_done  = done;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      pending_q       = '0;
      level_q         = '0;
      ticks_q         = '0;
      depth_q         = '0;
      service_ticks_q = SERVICE_TICKS_RST;
      expected_status_q.delete();
      fail_count_o    = 0;
      waiting_o      <= 0;
    end else begin
      if (cfg_we_i)
        service_ticks_q = cfg_wdata_i;
      // take the result first: it always belongs to an older transaction
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RES_W-1:0]);
        if (expected_status_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 0, got);
        end else begin
          want = expected_status_q.pop_front();
          if (got.current_level !== want.current_level)
            report_mismatch("current_level", want.current_level, got.current_level);
          if (got.pending_mask !== want.pending_mask)
            report_mismatch("pending_mask", want.pending_mask, got.pending_mask);
          if (got.nesting_depth !== want.nesting_depth)
            report_mismatch("nesting_depth", want.nesting_depth, got.nesting_depth);
          if (got.ticks_left !== want.ticks_left)
            report_mismatch("ticks_left", want.ticks_left, got.ticks_left);
          if (got.handler_done !== want.handler_done)
            report_mismatch("handler_done", want.handler_done, got.handler_done);
          if (m_axis_tdata[23:RES_W] !== '0)
            report_mismatch("tdata padding", 0, m_axis_tdata[23:RES_W]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_status_q.push_back(predict_status(s_axis_tuser,
                                                   s_axis_tdata[LVL_W-1:0]));
      waiting_o <= expected_status_q.size();
    end
  end

endmodule

[test/tb_nested_priority_interrupt_controller.sv]
// Testbench top for the nested priority interrupt controller: clock, reset,
// directed and random tick/request stimulus, register writes and the verdict.
// Depends on npic_pkg, npic_checker and the controller RTL.
`timescale 1ns / 1ps

module tb_nested_priority_interrupt_controller;
  import npic_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [TICK_W-1:0] cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;

  int fail_count;
  int waiting;
  int sent_count  = 0;
  int rx_idle_pct = 0;

  nested_priority_interrupt_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  npic_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .waiting_o     (waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_event(input logic mode, input logic [LVL_W-1:0] lvl);
    int tx_idle_pct;
    // receiver idles more first, then the sender, then neither
    tx_idle_pct = (sent_count < 350) ? 36 : (sent_count < 700) ? 53 : 0;
    rx_idle_pct = (sent_count < 350) ? 53 : (sent_count < 700) ? 36 : 0;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 8'(lvl);
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
  endtask

  task automatic set_service_ticks(input logic [TICK_W-1:0] value);
    wait_drained();
    // let the two-stage pipeline settle before touching the register
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int tick_pct);
    repeat (count) begin
      if ($urandom_range(99) < tick_pct)
        send_event(MODE_TICK, LVL_W'($urandom_range(7)));
      else if ($urandom_range(9) == 0)
        send_event(MODE_REQUEST, LVL_W'($urandom_range(7)));
      else
        send_event(MODE_REQUEST, LVL_W'($urandom_range(NUM_LEVELS, 1)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_TICK;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle tick, out-of-range levels, nesting, requests at or below
    // the current level, completion with preemption by a pending level.
    send_event(MODE_TICK, 3'd0);
    send_event(MODE_REQUEST, 3'd0);
    send_event(MODE_REQUEST, 3'd5);
    send_event(MODE_REQUEST, 3'd7);
    send_event(MODE_REQUEST, 3'd1);
    send_event(MODE_REQUEST, 3'd1);
    send_event(MODE_REQUEST, 3'd3);
    send_event(MODE_REQUEST, 3'd2);
    send_event(MODE_REQUEST, 3'd4);
    send_event(MODE_REQUEST, 3'd4);
    repeat (15) send_event(MODE_TICK, 3'd0);

    set_service_ticks(8'd1);
    random_phase(150, 60);
    set_service_ticks(8'd3);
    random_phase(150, 55);
    set_service_ticks(8'd255);
    random_phase(300, 92);
    // zero wraps to a 256-tick handler
    set_service_ticks(8'd0);
    random_phase(300, 92);
    set_service_ticks(TICK_W'($urandom_range(9, 2)));
    random_phase(125, 55);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
